// ===== rtl/binary_lifting_lca_macros.svh =====
// Assertion macros used by the ancestor engine checker.
`ifndef BINARY_LIFTING_LCA_MACROS_SVH
`define BINARY_LIFTING_LCA_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BLCA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blca assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BLCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blca assertion failed");

`endif

// ===== rtl/blca_pkg.sv =====
// Types, constants and microcode ROM of the binary lifting ancestor engine.
`timescale 1ns / 1ps

package blca_pkg;

   localparam int NODE_W      = 10;
   localparam int DEPTH_W     = 10;
   localparam int DIST_W      = 11;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;
   localparam int PC_W        = 5;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [DEPTH_W-1:0] depth_type;
   typedef logic [DIST_W-1:0]  dist_type;
   typedef logic [PC_W-1:0]    pc_type;

   // memory read issued by a step
   typedef enum logic [2:0] {
      RD_NONE, RD_DEP_A, RD_DEP_B, RD_JMP_A, RD_JMP_B
   } rd_type;

   // where the registered read data lands
   typedef enum logic [2:0] {
      CAP_NONE, CAP_DA, CAP_DB, CAP_A, CAP_B, CAP_T, CAP_CMP
   } cap_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_LVL_INC, OP_LVL_DEC, OP_LVL_TOP, OP_ORDER
   } op_type;

   typedef enum logic [1:0] {
      WR_NONE, WR_LOAD, WR_JMP
   } wr_type;

   typedef enum logic [2:0] {
      C_NEVER, C_ALWAYS, C_A_ZERO, C_NO_LIFT, C_A_EQ_B,
      C_LVL_ZERO, C_LVL_LAST, C_LVL_NOT_LAST
   } cond_type;

   typedef struct packed {
      rd_type   rd;
      cap_type  cap;
      op_type   op;
      wr_type   wr;
      cond_type cond;
      pc_type   target;
      logic     emit;
      logic     finish;
   } uword_type;

   typedef struct packed {
      logic      en;
      uword_type w;
   } ctl_type;

   typedef struct packed {
      logic a_zero;
      logic a_eq_b;
      logic lift;
      logic lvl_zero;
      logic lvl_last;
      logic out_busy;
   } status_type;

   // program entry points and branch targets
   localparam pc_type PC_L_ENTRY = 5'd0;
   localparam pc_type PC_L_LOOP  = 5'd3;
   localparam pc_type PC_Q_ENTRY = 5'd7;
   localparam pc_type PC_Q_LIFT  = 5'd11;
   localparam pc_type PC_Q_NEXT  = 5'd16;
   localparam pc_type PC_Q_SAME  = 5'd18;
   localparam pc_type PC_Q_CLIMB = 5'd19;
   localparam pc_type PC_Q_LAST  = 5'd24;
   localparam pc_type PC_Q_FIN   = 5'd26;
   localparam pc_type PC_END     = 5'd29;

   function automatic uword_type uw(input rd_type rd, input cap_type cap, input op_type op,
                                    input wr_type wr, input cond_type cond,
                                    input pc_type target, input logic emit,
                                    input logic finish);
      uword_type w;
      w.rd     = rd;
      w.cap    = cap;
      w.op     = op;
      w.wr     = wr;
      w.cond   = cond;
      w.target = target;
      w.emit   = emit;
      w.finish = finish;
      return w;
   endfunction

   // microcode ROM
   function automatic uword_type ucode(input pc_type pc);
      uword_type w;
      case (pc)
         // load: depth and level-0 jump
         PC_L_ENTRY:      w = uw(RD_DEP_B, CAP_NONE, OP_NONE, WR_NONE, C_A_ZERO,
                                 PC_END, 1'b0, 1'b0);
         PC_L_ENTRY + 1:  w = uw(RD_NONE, CAP_DB, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_L_ENTRY + 2:  w = uw(RD_NONE, CAP_NONE, OP_NONE, WR_LOAD, C_LVL_LAST,
                                 PC_END, 1'b0, 1'b0);
         // load: upper levels, one ancestor hop per level
         PC_L_LOOP:       w = uw(RD_JMP_B, CAP_NONE, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_L_LOOP + 1:   w = uw(RD_NONE, CAP_B, OP_LVL_INC, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_L_LOOP + 2:   w = uw(RD_NONE, CAP_NONE, OP_NONE, WR_JMP, C_LVL_NOT_LAST,
                                 PC_L_LOOP, 1'b0, 1'b0);
         PC_L_LOOP + 3:   w = uw(RD_NONE, CAP_NONE, OP_NONE, WR_NONE, C_ALWAYS,
                                 PC_END, 1'b0, 1'b0);
         // query: fetch both depths, put the deeper node in b
         PC_Q_ENTRY:      w = uw(RD_DEP_A, CAP_NONE, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_Q_ENTRY + 1:  w = uw(RD_DEP_B, CAP_DA, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_Q_ENTRY + 2:  w = uw(RD_NONE, CAP_DB, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_Q_ENTRY + 3:  w = uw(RD_NONE, CAP_NONE, OP_ORDER, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         // query: lift b to the depth of a
         PC_Q_LIFT:       w = uw(RD_NONE, CAP_NONE, OP_NONE, WR_NONE, C_NO_LIFT,
                                 PC_Q_NEXT, 1'b0, 1'b0);
         PC_Q_LIFT + 1:   w = uw(RD_JMP_B, CAP_NONE, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_Q_LIFT + 2:   w = uw(RD_NONE, CAP_B, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_Q_LIFT + 3:   w = uw(RD_DEP_B, CAP_NONE, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_Q_LIFT + 4:   w = uw(RD_NONE, CAP_DB, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_Q_NEXT:       w = uw(RD_NONE, CAP_NONE, OP_NONE, WR_NONE, C_LVL_ZERO,
                                 PC_Q_SAME, 1'b0, 1'b0);
         PC_Q_NEXT + 1:   w = uw(RD_NONE, CAP_NONE, OP_LVL_DEC, WR_NONE, C_ALWAYS,
                                 PC_Q_LIFT, 1'b0, 1'b0);
         // query: climb both nodes while their ancestors differ
         PC_Q_SAME:       w = uw(RD_NONE, CAP_NONE, OP_LVL_TOP, WR_NONE, C_A_EQ_B,
                                 PC_Q_FIN, 1'b0, 1'b0);
         PC_Q_CLIMB:      w = uw(RD_JMP_A, CAP_NONE, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_Q_CLIMB + 1:  w = uw(RD_JMP_B, CAP_T, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_Q_CLIMB + 2:  w = uw(RD_NONE, CAP_CMP, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_Q_CLIMB + 3:  w = uw(RD_NONE, CAP_NONE, OP_NONE, WR_NONE, C_LVL_ZERO,
                                 PC_Q_LAST, 1'b0, 1'b0);
         PC_Q_CLIMB + 4:  w = uw(RD_NONE, CAP_NONE, OP_LVL_DEC, WR_NONE, C_ALWAYS,
                                 PC_Q_CLIMB, 1'b0, 1'b0);
         PC_Q_LAST:       w = uw(RD_JMP_A, CAP_NONE, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_Q_LAST + 1:   w = uw(RD_NONE, CAP_A, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         // query: depth of the ancestor, then the result beat
         PC_Q_FIN:        w = uw(RD_DEP_A, CAP_NONE, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_Q_FIN + 1:    w = uw(RD_NONE, CAP_DA, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b0);
         PC_Q_FIN + 2:    w = uw(RD_NONE, CAP_NONE, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b1, 1'b1);
         default:         w = uw(RD_NONE, CAP_NONE, OP_NONE, WR_NONE, C_NEVER,
                                 PC_END, 1'b0, 1'b1);
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/blca_seq.sv =====
// Microcode sequencer: step counter, ROM fetch and conditional branch.
`timescale 1ns / 1ps

module blca_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_accept,
   input  logic                   req_query,
   input  blca_pkg::status_type   status,
   output blca_pkg::ctl_type      ctl,
   output logic                   idle
);
   import blca_pkg::*;

   pc_type    pc_ff, pc_in;
   logic      busy_ff, busy_in;
   uword_type word;
   logic      stall;
   logic      run;
   logic      taken;

   assign word  = ucode(pc_ff);
   // result step waits while the output register is still full
   assign stall = word.emit & status.out_busy;
   assign run   = busy_ff & ~stall;

   always_comb begin
      case (word.cond)
         C_NEVER:        taken = 1'b0;
         C_ALWAYS:       taken = 1'b1;
         C_A_ZERO:       taken = status.a_zero;
         C_NO_LIFT:      taken = ~status.lift;
         C_A_EQ_B:       taken = status.a_eq_b;
         C_LVL_ZERO:     taken = status.lvl_zero;
         C_LVL_LAST:     taken = status.lvl_last;
         C_LVL_NOT_LAST: taken = ~status.lvl_last;
         default:        taken = 1'b0;
      endcase
   end

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (req_accept) begin
         busy_in = 1'b1;
         pc_in   = req_query ? PC_Q_ENTRY : PC_L_ENTRY;
      end else if (run) begin
         if (word.finish) begin
            busy_in = 1'b0;
         end
         pc_in = taken ? word.target : pc_ff + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= PC_L_ENTRY;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   assign ctl.en = run;
   assign ctl.w  = word;
   assign idle   = ~busy_ff;

endmodule

// ===== rtl/blca_dp.sv =====
// Datapath: node and depth registers, depth and jump memories, result register.
`timescale 1ns / 1ps

module blca_dp #(
   parameter int NODES  = 1024,
   parameter int LEVELS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_accept,
   input  blca_pkg::node_type     node_a,
   input  blca_pkg::node_type     node_b,
   input  blca_pkg::ctl_type      ctl,
   output blca_pkg::status_type   status,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output blca_pkg::node_type     ancestor,
   output blca_pkg::dist_type     distance
);
   import blca_pkg::*;

   localparam int AW     = $clog2(NODES);
   localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int JAW    = AW + LW;
   localparam int JDEPTH = NODES * (2 ** LW);
   localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

   depth_type dep_mem [NODES];
   node_type  jmp_mem [JDEPTH];

   node_type        a_ff, a_in, b_ff, b_in, t_ff, t_in;
   depth_type       da_ff, da_in, db_ff, db_in;
   dist_type        sa_ff, sa_in;
   logic [LW-1:0]   lvl_ff, lvl_in;
   node_type        anc_ff, anc_in;
   dist_type        dist_ff, dist_in;
   logic            valid_ff;

   depth_type       dep_q;
   node_type        jmp_q;
   logic            rd_zero_ff, rd_jmp_ff;
   logic [9:0]      rdata;

   logic            dep_re, jmp_re, dep_we, jmp_we;
   logic [AW-1:0]   dep_ra;
   logic [JAW-1:0]  jmp_ra, jmp_wa;
   node_type        rd_node;
   depth_type       dep_wd;
   logic [DIST_W-1:0] dep_inc;
   logic [16:0]     reach;
   logic signed [DIST_W+1:0] dist_raw;

   function automatic node_type node_map(input node_type n);
      return (32'(n) < NODES) ? n : '0;
   endfunction

   function automatic logic [AW-1:0] to_addr(input node_type n);
      logic [16:0] w;
      w = 17'(n);
      return w[AW-1:0];
   endfunction

   // read address and port select
   always_comb begin
      case (ctl.w.rd)
         RD_DEP_A, RD_JMP_A: rd_node = a_ff;
         RD_DEP_B, RD_JMP_B: rd_node = b_ff;
         default:            rd_node = b_ff;
      endcase
      dep_re = ctl.en && (ctl.w.rd == RD_DEP_A || ctl.w.rd == RD_DEP_B);
      jmp_re = ctl.en && (ctl.w.rd == RD_JMP_A || ctl.w.rd == RD_JMP_B);
   end

   assign dep_ra = to_addr(rd_node);
   assign jmp_ra = {to_addr(rd_node), lvl_ff};

   // writes always go to the loaded node, at the current level
   assign dep_inc = {1'b0, db_ff} + DIST_W'(1);
   assign dep_wd  = (dep_inc > {1'b0, DEPTH_MAX}) ? DEPTH_MAX : dep_inc[DEPTH_W-1:0];
   assign dep_we  = ctl.en && (ctl.w.wr == WR_LOAD);
   assign jmp_we  = ctl.en && (ctl.w.wr != WR_NONE);
   assign jmp_wa  = {to_addr(a_ff), lvl_ff};

   always_ff @(posedge clock) begin
      if (dep_we) begin
         dep_mem[to_addr(a_ff)] <= dep_wd;
      end
      if (dep_re) begin
         dep_q <= dep_mem[dep_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (jmp_we) begin
         jmp_mem[jmp_wa] <= b_ff;
      end
      if (jmp_re) begin
         jmp_q <= jmp_mem[jmp_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (dep_re || jmp_re) begin
         rd_zero_ff <= (rd_node == '0);
         rd_jmp_ff  <= jmp_re;
      end
   end

   // node 0 is the root: depth 0, every ancestor 0
   assign rdata = rd_zero_ff ? '0 : (rd_jmp_ff ? jmp_q : dep_q);

   assign reach    = 17'(da_ff) + (17'd1 << lvl_ff);
   assign dist_raw = $signed({2'b00, sa_ff}) - $signed({2'b00, da_ff, 1'b0});

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      t_in    = t_ff;
      da_in   = da_ff;
      db_in   = db_ff;
      sa_in   = sa_ff;
      lvl_in  = lvl_ff;
      anc_in  = anc_ff;
      dist_in = dist_ff;
      if (req_accept) begin
         a_in   = node_map(node_a);
         b_in   = node_map(node_b);
         lvl_in = '0;
      end else if (ctl.en) begin
         case (ctl.w.cap)
            CAP_DA:  da_in = rdata;
            CAP_DB:  db_in = rdata;
            CAP_A:   a_in  = rdata;
            CAP_B:   b_in  = rdata;
            CAP_T:   t_in  = rdata;
            CAP_CMP: begin
               if (t_ff != rdata) begin
                  a_in = t_ff;
                  b_in = rdata;
               end
            end
            default: ;
         endcase
         case (ctl.w.op)
            OP_LVL_INC: lvl_in = lvl_ff + LW'(1);
            OP_LVL_DEC: lvl_in = lvl_ff - LW'(1);
            OP_LVL_TOP: lvl_in = LVL_TOP;
            OP_ORDER: begin
               sa_in  = {1'b0, da_ff} + {1'b0, db_ff};
               lvl_in = LVL_TOP;
               if (da_ff > db_ff) begin
                  a_in  = b_ff;
                  b_in  = a_ff;
                  da_in = db_ff;
                  db_in = da_ff;
               end
            end
            default: ;
         endcase
         if (ctl.w.emit) begin
            anc_in  = a_ff;
            dist_in = dist_raw[DIST_W+1] ? '0 : dist_raw[DIST_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      t_ff    <= t_in;
      da_ff   <= da_in;
      db_ff   <= db_in;
      sa_ff   <= sa_in;
      lvl_ff  <= lvl_in;
      anc_ff  <= anc_in;
      dist_ff <= dist_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.en && ctl.w.emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   assign status.a_zero   = (a_ff == '0);
   assign status.a_eq_b   = (a_ff == b_ff);
   assign status.lift     = (17'(db_ff) >= reach);
   assign status.lvl_zero = (lvl_ff == '0);
   assign status.lvl_last = (lvl_ff == LVL_TOP);
   assign status.out_busy = valid_ff & ~rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign ancestor   = anc_ff;
   assign distance   = dist_ff;

endmodule

// ===== rtl/binary_lifting_lca.sv =====
// Top level of the binary lifting lowest-common-ancestor engine.
`timescale 1ns / 1ps
// Usage:
//  - req channel: one beat per command. tuser = cmd (0 load, 1 query).
//    Load: node_a gets parent node_b; loads must arrive top-down (parent first).
//    Query: returns lowest common ancestor of node_a and node_b and their
//    distance in edges. Node 0 is the fixed root; node ids >= NODES read as 0.
//  - rsp channel: one beat per query, none per load.
//  - One command is in flight at a time; req_tready is high only while idle.
//  - Timing is set by the microcode program and the single read port of the
//    jump memory (one read per step, read data registered):
//      load  : one ancestor hop per level
//      query : grows with every level where the deeper node is lifted; a
//              node pair that meets after lifting skips the climb.
//  - Result sits in an output register; while it is full and rsp_tready is low
//    the result step of the next query holds, so nothing is lost.
//  - Reset (synchronous, active high) idles the sequencer and drops rsp_tvalid.
//    Memories are not cleared; only nodes that were loaded may be queried.

module binary_lifting_lca #(
   parameter int NODES  = 1024,
   parameter int LEVELS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   // [9:0] node_a, [19:10] node_b, [23:20] zero
   input  logic [blca_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] cmd
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [9:0] ancestor, [20:10] distance, [23:21] zero
   output logic [blca_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);
   import blca_pkg::*;

   ctl_type    ctl;
   status_type status;
   logic       idle;
   logic       req_accept;
   node_type   node_a, node_b;
   node_type   ancestor;
   dist_type   distance;

   assign req_tready = idle;
   assign req_accept = req_tvalid & idle;

   assign node_a = req_tdata[NODE_W-1:0];
   assign node_b = req_tdata[2*NODE_W-1:NODE_W];

   // control: step counter walking the ROM program
   blca_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_query  (req_tuser),
      .status     (status),
      .ctl        (ctl),
      .idle       (idle)
   );

   // datapath: registers, depth and jump memories, result register
   blca_dp #(
      .NODES  (NODES),
      .LEVELS (LEVELS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .node_a     (node_a),
      .node_b     (node_b),
      .ctl        (ctl),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .ancestor   (ancestor),
      .distance   (distance)
   );

   assign rsp_tdata = {(RSP_TDATA_W - DIST_W - NODE_W)'(0), distance, ancestor};

endmodule

// ===== rtl/blca_chk.sv =====
// Port-level checker for the ancestor engine, bound to the top level.
`timescale 1ns / 1ps
`include "binary_lifting_lca_macros.svh"

module blca_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [blca_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import blca_pkg::*;

   // a command occupies the engine: no second beat right after one is taken
   `BLCA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

   // stalled result holds
   `BLCA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a result only comes out of a command in progress
   `BLCA_ASSERT_NOW(a_rsp_from_busy, clock, reset, $rose(rsp_tvalid), $past(!req_tready))

   // pad bits above the distance stay zero
   `BLCA_ASSERT_NOW(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[RSP_TDATA_W-1:DIST_W+NODE_W] == '0)

endmodule

bind binary_lifting_lca blca_chk u_blca_chk (.*);
